>>> design/dbsu_pkg.sv
// shared types, constants and helpers for the button sequence unlock core
package dbsu_pkg;

	localparam int HISTORY_LEN   = 21;
	localparam int BRIGHT_LEVELS = 6;
	localparam int EFFECT_LEVELS = 5;
	localparam int PTR_W         = $clog2(HISTORY_LEN);
	localparam int BRIGHT_W      = 3;
	localparam int EFFECT_W      = 3;
	localparam int LOCKOUT_W     = 16;
	localparam int KEY_W         = 42;
	localparam int TIME_W        = 32;
	localparam int CFG_IDX_W     = 3;
	localparam int IN_DATA_W     = 40;
	localparam int OUT_DATA_W    = 16;

	localparam logic [LOCKOUT_W-1:0] RESET_LOCKOUT = LOCKOUT_W'(200);
	localparam logic [KEY_W-1:0]     RESET_KEY     = 42'd2589793558437;

	localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAVE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESET  = 3'd4;

	localparam logic [1:0] BTN_BRIGHT = 2'd0;
	localparam logic [1:0] BTN_TOGGLE = 2'd1;
	localparam logic [1:0] BTN_EFFECT = 2'd2;

	localparam logic [1:0] CODE_BRIGHT = 2'd1;
	localparam logic [1:0] CODE_TOGGLE = 2'd2;
	localparam logic [1:0] CODE_EFFECT = 2'd3;

	localparam logic [EFFECT_W-1:0] FX_GREEN = 3'd0;
	localparam logic [EFFECT_W-1:0] FX_RED   = 3'd2;
	localparam logic [EFFECT_W-1:0] FX_WAVE  = 3'd3;
	localparam logic [EFFECT_W-1:0] FX_FIRE  = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_MATCH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                sparkle_active;
		logic                unlocked_now;
		logic                unlocked;
		logic [EFFECT_W-1:0] effect;
		logic                toggle_on;
		logic [BRIGHT_W-1:0] brightness;
		logic                accepted;
	} result_t;

	// skip disabled effects, out of range falls back to green
	function automatic logic [EFFECT_W-1:0] resolve_effect(
		input logic [EFFECT_W-1:0] fx,
		input logic                wave_en,
		input logic                fire_en
	);
		logic [EFFECT_W-1:0] res;
		res = FX_GREEN;
		if (fx <= FX_RED) begin
			res = fx;
		end else if (fx == FX_WAVE) begin
			res = wave_en ? FX_WAVE : (fire_en ? FX_FIRE : FX_GREEN);
		end else if (fx == FX_FIRE) begin
			res = fire_en ? FX_FIRE : FX_GREEN;
		end
		return res;
	endfunction

endpackage

>>> design/debounced_button_sequence_unlock_core.sv
// debounced button sequence unlock core with iterative key compare
//
// Input stream s_axis carries one button event per transaction (button id and
// millisecond timestamp). Each event yields exactly one result transaction on
// m_axis: acceptance flag, the brightness, toggle and effect counters and the
// unlock status. Configuration goes through cfg_we / cfg_index / cfg_data, and
// the user must write it only while the core is idle; the core does not enforce it.
// An event is taken in the idle state only. The update state applies the
// lockout check and the counter, history and pointer update; when the toggle is
// on and the mode is locked, a shared 2-bit comparator then walks the 21-entry
// history ring against the key, one entry per cycle, stopping at the first
// mismatch. The done state then loads the output register, so the core takes no
// new event until the result of the last one is loaded.
// If the receiver stalls, the result stays in the output register; the core
// still takes the next event and holds its result until the register frees.
// Reset clears counters, history and pointer, loads register reset values and
// leaves the core ready in the idle state.
module debounced_button_sequence_unlock_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [dbsu_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // button[1:0], time_ms[33:2]
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// accepted[0], brightness[3:1], toggle_on[4], effect[7:5], unlocked[8],
	// unlocked_now[9], sparkle_active[10]
	output logic [dbsu_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                           cfg_we,
	input  logic [dbsu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dbsu_pkg::KEY_W-1:0]      cfg_data
);

	dbsu_pkg::state_t state_q, state_d;

	logic [dbsu_pkg::LOCKOUT_W-1:0] lockout_q;
	logic [dbsu_pkg::KEY_W-1:0]     key_q;
	logic                           wave_q, fire_q;

	logic [1:0]                      button_q;
	logic [dbsu_pkg::TIME_W-1:0]     time_q;
	logic [dbsu_pkg::BRIGHT_W-1:0]   bright_q;
	logic                            toggle_q;
	logic [dbsu_pkg::EFFECT_W-1:0]   effect_q;
	logic [dbsu_pkg::TIME_W-1:0]     last_q;
	logic [1:0]                      hist_q [dbsu_pkg::HISTORY_LEN];
	logic [dbsu_pkg::PTR_W-1:0]      ptr_q;
	logic                            unlock_q;
	logic                            accepted_q;
	logic                            now_q;
	logic [dbsu_pkg::PTR_W-1:0]      pos_q;
	logic [dbsu_pkg::PTR_W-1:0]      idx_q;
	logic [dbsu_pkg::KEY_W-1:0]      key_sh_q;
	logic                            out_valid_q;
	dbsu_pkg::result_t               out_q;

	logic                            in_fire;
	logic                            out_free;
	logic [dbsu_pkg::TIME_W-1:0]     elapsed;
	logic                            pass;
	logic [dbsu_pkg::BRIGHT_W-1:0]   bright_upd;
	logic                            toggle_upd;
	logic [dbsu_pkg::EFFECT_W-1:0]   effect_upd;
	logic [dbsu_pkg::PTR_W-1:0]      ptr_next;
	logic                            entry_hit;
	logic                            last_entry;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign elapsed  = time_q - last_q;
	assign pass     = elapsed >= {{(dbsu_pkg::TIME_W-dbsu_pkg::LOCKOUT_W){1'b0}}, lockout_q};
	assign ptr_next = (ptr_q == dbsu_pkg::PTR_W'(dbsu_pkg::HISTORY_LEN-1)) ?
		'0 : ptr_q + 1'b1;
	assign entry_hit  = hist_q[pos_q] == key_sh_q[1:0];
	assign last_entry = idx_q == dbsu_pkg::PTR_W'(dbsu_pkg::HISTORY_LEN-1);

	always_comb begin
		bright_upd = bright_q;
		toggle_upd = toggle_q;
		effect_upd = effect_q;
		if (pass) begin
			case (button_q)
				dbsu_pkg::BTN_BRIGHT: begin
					bright_upd = (bright_q == dbsu_pkg::BRIGHT_W'(dbsu_pkg::BRIGHT_LEVELS-1)) ?
						'0 : bright_q + 1'b1;
				end
				dbsu_pkg::BTN_TOGGLE: begin
					toggle_upd = ~toggle_q;
				end
				dbsu_pkg::BTN_EFFECT: begin
					effect_upd = (effect_q >= dbsu_pkg::EFFECT_W'(dbsu_pkg::EFFECT_LEVELS-1)) ?
						'0 : effect_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
		effect_upd = dbsu_pkg::resolve_effect(effect_upd, wave_q, fire_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dbsu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		case (state_q)
			dbsu_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = dbsu_pkg::ST_UPDATE;
				end
			end
			dbsu_pkg::ST_UPDATE: begin
				state_d = (toggle_upd && !unlock_q) ? dbsu_pkg::ST_MATCH : dbsu_pkg::ST_DONE;
			end
			dbsu_pkg::ST_MATCH: begin
				if (!entry_hit || last_entry) begin
					state_d = dbsu_pkg::ST_DONE;
				end
			end
			dbsu_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = dbsu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dbsu_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_q  <= dbsu_pkg::RESET_LOCKOUT;
			key_q      <= dbsu_pkg::RESET_KEY;
			wave_q     <= 1'b0;
			fire_q     <= 1'b0;
			bright_q   <= '0;
			toggle_q   <= 1'b0;
			effect_q   <= '0;
			last_q     <= '0;
			ptr_q      <= '0;
			unlock_q   <= 1'b0;
			accepted_q <= 1'b0;
			now_q      <= 1'b0;
			pos_q      <= '0;
			idx_q      <= '0;
			for (int i = 0; i < dbsu_pkg::HISTORY_LEN; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					dbsu_pkg::CFG_LOCKOUT: lockout_q <= cfg_data[dbsu_pkg::LOCKOUT_W-1:0];
					dbsu_pkg::CFG_KEY:     key_q     <= cfg_data;
					dbsu_pkg::CFG_WAVE:    wave_q    <= cfg_data[0];
					dbsu_pkg::CFG_FIRE:    fire_q    <= cfg_data[0];
					dbsu_pkg::CFG_PRESET:  unlock_q  <= cfg_data[0];
					default: begin
					end
				endcase
			end
			case (state_q)
				dbsu_pkg::ST_UPDATE: begin
					accepted_q <= pass;
					now_q      <= 1'b0;
					bright_q   <= bright_upd;
					toggle_q   <= toggle_upd;
					effect_q   <= effect_upd;
					idx_q      <= '0;
					if (pass) begin
						last_q <= time_q;
						ptr_q  <= ptr_next;
						pos_q  <= ptr_next;
						case (button_q)
							dbsu_pkg::BTN_BRIGHT: hist_q[ptr_q] <= dbsu_pkg::CODE_BRIGHT;
							dbsu_pkg::BTN_TOGGLE: hist_q[ptr_q] <= dbsu_pkg::CODE_TOGGLE;
							dbsu_pkg::BTN_EFFECT: hist_q[ptr_q] <= dbsu_pkg::CODE_EFFECT;
							default: begin
							end
						endcase
					end else begin
						pos_q <= ptr_q;
					end
				end
				dbsu_pkg::ST_MATCH: begin
					if (!entry_hit) begin
						toggle_q <= 1'b0;
					end else if (last_entry) begin
						unlock_q <= 1'b1;
						bright_q <= '0;
						now_q    <= 1'b1;
					end
					idx_q <= idx_q + 1'b1;
					pos_q <= (pos_q == dbsu_pkg::PTR_W'(dbsu_pkg::HISTORY_LEN-1)) ?
						'0 : pos_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// event capture and key shift register
	always_ff @(posedge clk) begin
		if (in_fire) begin
			button_q <= s_axis_tdata[1:0];
			time_q   <= s_axis_tdata[dbsu_pkg::TIME_W+1:2];
		end
		if (state_q == dbsu_pkg::ST_UPDATE) begin
			key_sh_q <= key_q;
		end else if (state_q == dbsu_pkg::ST_MATCH) begin
			key_sh_q <= key_sh_q >> 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == dbsu_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == dbsu_pkg::ST_DONE && out_free) begin
			out_q.accepted       <= accepted_q;
			out_q.brightness     <= bright_q;
			out_q.toggle_on      <= toggle_q;
			out_q.effect         <= effect_q;
			out_q.unlocked       <= unlock_q;
			out_q.unlocked_now   <= now_q;
			out_q.sparkle_active <= toggle_q && unlock_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(dbsu_pkg::OUT_DATA_W-$bits(dbsu_pkg::result_t)){1'b0}}, out_q};

endmodule

>>> design/dbsu_checker.sv
// port-level checker for the button sequence unlock core, with its bind
module dbsu_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [dbsu_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	// held result transaction stays put while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[3:1] < 3'd6 && m_axis_tdata[7:5] <= 3'd4)
		else $error("counter out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[10] == (m_axis_tdata[4] && m_axis_tdata[8]))
		else $error("sparkle does not follow toggle and unlock");

	// completing the key leaves the mode unlocked, toggle on and brightness cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[9] |->
			m_axis_tdata[8] && m_axis_tdata[4] && m_axis_tdata[3:1] == 3'd0)
		else $error("unlock event with inconsistent state");

endmodule

bind debounced_button_sequence_unlock_core dbsu_checker u_dbsu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

>>> tb/sv/unlock_checker.sv
// status predictor and checker for the button sequence unlock core
`timescale 1ns / 1ps

module unlock_checker
	import dbsu_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // button[1:0], time_ms[33:2]
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// accepted[0], brightness[3:1], toggle_on[4], effect[7:5], unlocked[8],
	// unlocked_now[9], sparkle_active[10]
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [KEY_W-1:0]      cfg_data,
	input  logic                  finished,
	output int                    status_owed,
	output int                    mismatch_count
);

	logic [LOCKOUT_W-1:0] lockout_r;
	logic [KEY_W-1:0]     key_r;
	logic                 wave_r;
	logic                 fire_r;

	logic [BRIGHT_W-1:0]  bright;
	logic                 tog;
	logic [EFFECT_W-1:0]  fx;
	logic [TIME_W-1:0]    last_t;
	logic [1:0]           hist [HISTORY_LEN];
	logic [PTR_W-1:0]     ptr;
	logic                 unlocked;

	result_t              predicted_status [$];
	result_t              got;
	result_t              want;
	logic                 closed;
	int                   k;

	task automatic report_mismatch(input string what, input int seen, input int wanted);
		$display("%0t mismatch, %s: got %0d expected %0d", $realtime, what, seen, wanted);
		mismatch_count++;
	endtask

	function automatic result_t predict_press(input logic [1:0] btn,
						  input logic [TIME_W-1:0] now);
		result_t r;
		logic    hit;
		int      i;
		r = '0;
		if (TIME_W'(now - last_t) >= TIME_W'(lockout_r)) begin
			r.accepted = 1'b1;
			case (btn)
				BTN_BRIGHT: begin
					bright = (bright == BRIGHT_W'(BRIGHT_LEVELS - 1)) ? '0 : bright + 1'b1;
					hist[ptr] = CODE_BRIGHT;
				end
				BTN_TOGGLE: begin
					tog = ~tog;
					hist[ptr] = CODE_TOGGLE;
				end
				BTN_EFFECT: begin
					fx = (fx == EFFECT_W'(EFFECT_LEVELS - 1)) ? FX_GREEN : fx + 1'b1;
					hist[ptr] = CODE_EFFECT;
				end
				default: ;
			endcase
			last_t = now;
			ptr = (ptr == PTR_W'(HISTORY_LEN - 1)) ? '0 : ptr + 1'b1;
		end
		// disabled effects roll forward until an enabled one or green
		for (i = 0; i < 3; i++) begin
			if (fx == FX_WAVE && !wave_r)
				fx = FX_FIRE;
			else if (fx == FX_FIRE && !fire_r)
				fx = FX_GREEN;
			else if (fx > FX_FIRE)
				fx = FX_GREEN;
		end
		if (tog && !unlocked) begin
			hit = 1'b1;
			for (i = 0; i < HISTORY_LEN; i++)
				if (hist[(i + int'(ptr)) % HISTORY_LEN] != key_r[2*i +: 2])
					hit = 1'b0;
			if (hit) begin
				unlocked = 1'b1;
				bright = '0;
				r.unlocked_now = 1'b1;
			end else begin
				tog = 1'b0;
			end
		end
		r.brightness = bright;
		r.toggle_on = tog;
		r.effect = fx;
		r.unlocked = unlocked;
		r.sparkle_active = tog && unlocked;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_r = RESET_LOCKOUT;
			key_r = RESET_KEY;
			wave_r = 1'b0;
			fire_r = 1'b0;
			bright = '0;
			tog = 1'b0;
			fx = FX_GREEN;
			last_t = '0;
			for (k = 0; k < HISTORY_LEN; k++)
				hist[k] = '0;
			ptr = '0;
			unlocked = 1'b0;
			predicted_status.delete();
			mismatch_count = 0;
			status_owed = 0;
			closed = 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_LOCKOUT: lockout_r = cfg_data[LOCKOUT_W-1:0];
					CFG_KEY:     key_r = cfg_data;
					CFG_WAVE:    wave_r = cfg_data[0];
					CFG_FIRE:    fire_r = cfg_data[0];
					CFG_PRESET:  unlocked = cfg_data[0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				predicted_status.push_back(predict_press(s_axis_tdata[1:0],
									 s_axis_tdata[TIME_W+1:2]));
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[$bits(result_t)-1:0];
				if (predicted_status.size() == 0) begin
					report_mismatch("status with no event pending", int'(got), 0);
				end else begin
					want = predicted_status.pop_front();
					if (got.accepted != want.accepted)
						report_mismatch("accepted", got.accepted, want.accepted);
					if (got.brightness != want.brightness)
						report_mismatch("brightness", got.brightness, want.brightness);
					if (got.toggle_on != want.toggle_on)
						report_mismatch("toggle_on", got.toggle_on, want.toggle_on);
					if (got.effect != want.effect)
						report_mismatch("effect", got.effect, want.effect);
					if (got.unlocked != want.unlocked)
						report_mismatch("unlocked", got.unlocked, want.unlocked);
					if (got.unlocked_now != want.unlocked_now)
						report_mismatch("unlocked_now", got.unlocked_now,
								want.unlocked_now);
					if (got.sparkle_active != want.sparkle_active)
						report_mismatch("sparkle_active", got.sparkle_active,
								want.sparkle_active);
				end
			end
			if (finished && !closed) begin
				closed = 1'b1;
				if (predicted_status.size() != 0)
					report_mismatch("status transactions never returned", 0,
							predicted_status.size());
			end
			status_owed = predicted_status.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
// stimulus and verdict for the button sequence unlock core
`timescale 1ns / 1ps

module testbench;
	import dbsu_pkg::*;

	localparam logic [1:0] BTN_OTHER      = 2'd3;
	localparam int         DIRECTED_ITEMS = 24;
	localparam int         RANDOM_ITEMS   = 340;
	localparam int         DRAIN_CYCLES   = 30;
	localparam int         END_LIMIT      = 20000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [KEY_W-1:0]      cfg_data;
	logic                  finished;
	logic                  calm;
	int                    status_owed;
	int                    mismatch_count;

	logic [LOCKOUT_W-1:0]  lockout_now;
	logic [TIME_W-1:0]     t_press;
	int                    n_sent;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	debounced_button_sequence_unlock_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	unlock_checker u_unlock_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.finished      (finished),
		.status_owed   (status_owed),
		.mismatch_count(mismatch_count)
	);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= calm || ($urandom_range(0, 99) >= 11);
	end

	task automatic send_event(input logic [1:0] btn, input logic [TIME_W-1:0] stamp);
		while (!calm && $urandom_range(0, 99) < 11) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_DATA_W'({stamp, btn});
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		n_sent++;
	endtask

	// a press spaced far enough from the previous one to pass the lockout
	task automatic tap(input logic [1:0] btn);
		t_press = t_press + lockout_now + $urandom_range(0, 300);
		send_event(btn, t_press);
	endtask

	task automatic wait_idle;
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (status_owed != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [LOCKOUT_W-1:0] lock, input logic [KEY_W-1:0] key_val,
				 input logic wave_en, input logic fire_en, input logic preset);
		cfg_we <= 1'b1;
		cfg_index <= CFG_LOCKOUT;
		cfg_data <= KEY_W'(lock);
		@(posedge clk);
		cfg_index <= CFG_KEY;
		cfg_data <= key_val;
		@(posedge clk);
		cfg_index <= CFG_WAVE;
		cfg_data <= KEY_W'(wave_en);
		@(posedge clk);
		cfg_index <= CFG_FIRE;
		cfg_data <= KEY_W'(fire_en);
		@(posedge clk);
		cfg_index <= CFG_PRESET;
		cfg_data <= KEY_W'(preset);
		@(posedge clk);
		cfg_we <= 1'b0;
		lockout_now = lock;
	endtask

	// key presses in order, with contact bounce and the odd stray pin
	task automatic enter_key(input logic [KEY_W-1:0] key_val);
		logic [1:0] btn;
		int         i;
		for (i = 0; i < HISTORY_LEN; i++) begin
			case (key_val[2*i +: 2])
				CODE_BRIGHT: btn = BTN_BRIGHT;
				CODE_TOGGLE: btn = BTN_TOGGLE;
				CODE_EFFECT: btn = BTN_EFFECT;
				default:     btn = BTN_OTHER;
			endcase
			if (lockout_now != 0 && $urandom_range(0, 5) == 0)
				send_event(2'($urandom_range(0, 3)),
					   t_press + $urandom_range(0, int'(lockout_now) - 1));
			if ($urandom_range(0, 39) == 0)
				tap(BTN_OTHER);
			tap(btn);
		end
	endtask

	task automatic noise_burst(input int count);
		logic [TIME_W-1:0] stamp;
		int                i;
		for (i = 0; i < count; i++) begin
			if ($urandom_range(0, 1) == 0)
				stamp = $urandom;
			else
				stamp = t_press + $urandom_range(0, 2 * int'(lockout_now) + 1);
			send_event(2'($urandom_range(0, 3)), stamp);
			t_press = stamp;
		end
	endtask

	initial begin
		logic [KEY_W-1:0]     key_val;
		logic [LOCKOUT_W-1:0] lock;
		logic [TIME_W-1:0]    base;
		int                   phase;
		int                   pick;
		int                   i;
		int                   spin;

		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_LOCKOUT;
		cfg_data <= '0;
		finished <= 1'b0;
		calm <= 1'b0;
		lockout_now = RESET_LOCKOUT;
		t_press = '0;
		n_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// early presses against a zero start time, window boundary, other pin
		send_event(BTN_BRIGHT, 32'd0);
		send_event(BTN_TOGGLE, 32'd199);
		send_event(BTN_BRIGHT, 32'd200);
		send_event(BTN_OTHER, 32'd399);
		send_event(BTN_OTHER, 32'd400);
		send_event(BTN_TOGGLE, 32'd600);
		send_event(BTN_EFFECT, 32'd800);
		send_event(BTN_EFFECT, 32'd1000);
		send_event(BTN_EFFECT, 32'd1200);

		// no lockout, all effects on, counters wrap
		wait_idle();
		configure('0, RESET_KEY, 1'b1, 1'b1, 1'b0);
		send_event(BTN_EFFECT, 32'hFFFF_FFFF);
		send_event(BTN_EFFECT, 32'd0);
		send_event(BTN_EFFECT, 32'd5);
		send_event(BTN_EFFECT, 32'd5);
		send_event(BTN_EFFECT, 32'd17);
		send_event(BTN_BRIGHT, 32'd7);
		send_event(BTN_BRIGHT, 32'd7);
		send_event(BTN_BRIGHT, 32'd100);
		send_event(BTN_BRIGHT, 32'h8000_0000);
		send_event(BTN_BRIGHT, 32'd3);
		send_event(BTN_BRIGHT, 32'hFFFF_FFF0);

		// widest window across the time wrap, preset unlock
		wait_idle();
		configure('1, RESET_KEY, 1'b1, 1'b0, 1'b1);
		base = 32'hFFFF_FFF0;
		send_event(BTN_TOGGLE, base + 32'd65534);
		send_event(BTN_TOGGLE, base + 32'd65535);

		// all-ones key, locked again
		wait_idle();
		configure('1, '1, 1'b0, 1'b1, 1'b0);
		base = base + 32'd65535;
		send_event(BTN_TOGGLE, base + 32'd65535);
		send_event(BTN_TOGGLE, base + 32'd131070);
		t_press = base + 32'd131070;

		phase = 0;
		while (n_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			wait_idle();
			pick = $urandom_range(0, 7);
			if (phase == 1) begin
				key_val = '0;
			end else if (pick == 0) begin
				key_val = RESET_KEY;
			end else if (pick == 1) begin
				key_val = {10'($urandom), 32'($urandom)};
			end else begin
				for (i = 0; i < HISTORY_LEN - 1; i++)
					key_val[2*i +: 2] = 2'($urandom_range(1, 3));
				key_val[KEY_W-1 -: 2] = CODE_TOGGLE;
			end
			pick = $urandom_range(0, 5);
			if (pick == 0)
				lock = '0;
			else if (pick == 1)
				lock = '1;
			else
				lock = LOCKOUT_W'($urandom_range(1, 1000));
			configure(lock, key_val, 1'($urandom), 1'($urandom),
				  $urandom_range(0, 4) == 0);
			calm <= (phase == 3);
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 3) != 0)
					enter_key(key_val);
				else
					noise_burst($urandom_range(3, 12));
			end
			phase++;
		end

		s_axis_tvalid <= 1'b0;
		spin = 0;
		@(negedge clk);
		while (status_owed != 0 && spin < END_LIMIT) begin
			@(negedge clk);
			spin++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		finished <= 1'b1;
		repeat (2) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

>>> sim.f
design/dbsu_pkg.sv
design/debounced_button_sequence_unlock_core.sv
design/dbsu_checker.sv
tb/sv/unlock_checker.sv
tb/sv/testbench.sv
